[rtl/ctsa_pkg.sv]
// shared types and constants for the counter to timespec accumulator
// no dependencies

`default_nettype none

package ctsa_pkg;

  localparam int unsigned COUNTER_WIDTH = 64;
  localparam int unsigned DIV_W         = 64;
  localparam int unsigned DVS_W         = 32;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_W + 1);
  localparam int unsigned NS_W          = 30;
  localparam int unsigned PROD_W        = DVS_W + NS_W;

  localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_REBASE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] counter_value;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]     seconds;
    logic [NS_W-1:0] nanoseconds;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/ctsa_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on ctsa_pkg

`default_nettype none

module ctsa_div
  import ctsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;
  logic             ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~trial[DVS_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W);
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

[rtl/counter_to_timespec_accumulator.sv]
// top level: wall time in seconds and nanoseconds from free-running counter readings
// depends on ctsa_pkg and ctsa_div
//
// channel | beat                          | handshake
// cfg     | clock_frequency (32 bits)     | cfg_valid_i / cfg_ready_o
// in      | in_beat_t: command, reading   | in_valid_i / in_ready_o
// out     | out_beat_t: seconds, ns       | out_valid_o / out_ready_i
//
// an update runs two passes of the shared 64-step divider
// (elapsed / freq, then remainder * 1e9 / freq), with a multiply step between them and an add step after
// a rebase, or an update with zero frequency, skips the divider and goes straight to the output hand-off
// reset clears the time, the last reading and the frequency
// one item at a time; the result waits in an output register, a stalled output
// holds only the final hand-off

`default_nettype none

module counter_to_timespec_accumulator
  import ctsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_beat_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_beat_t        out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV1   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_START2 = 3'd3;
  localparam logic [2:0] ST_DIV2   = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [DVS_W-1:0]         freq_q, freq_d;
  logic [COUNTER_WIDTH-1:0] last_q, last_d;
  logic [COUNTER_WIDTH-1:0] rd_q, rd_d;
  logic [63:0]              sec_q, sec_d;
  logic [NS_W-1:0]          ns_q, ns_d;
  logic [DIV_W-1:0]         whole_q, whole_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  out_beat_t                out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [COUNTER_WIDTH-1:0] reading;
  logic [COUNTER_WIDTH-1:0] elapsed;
  logic [NS_W:0]            ns_sum;
  logic                     ns_carry;
  logic                     in_fire;

  ctsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign reading     = in_data_i.counter_value[COUNTER_WIDTH-1:0];
  assign elapsed     = reading - last_q;
  assign ns_sum      = {1'b0, ns_q} + {1'b0, div_rsp.quotient[NS_W-1:0]};
  assign ns_carry    = (ns_sum >= {1'b0, NS_PER_SEC});

  always_comb begin
    state_d          = state_q;
    freq_d           = freq_q;
    last_d           = last_q;
    rd_d             = rd_q;
    sec_d            = sec_q;
    ns_d             = ns_q;
    whole_d          = whole_q;
    prod_d           = prod_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q & ~out_ready_i;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(elapsed);
    div_req.divisor  = freq_q;

    if (cfg_valid_i && cfg_ready_o) begin
      freq_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.command == CMD_REBASE) begin
            last_d  = reading;
            state_d = ST_DONE;
          end else if (freq_q == '0) begin
            state_d = ST_DONE;
          end else begin
            rd_d          = reading;
            div_req.start = 1'b1;
            state_d       = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          whole_d = div_rsp.quotient;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = {{NS_W{1'b0}}, div_rsp.remainder} * {{DVS_W{1'b0}}, NS_PER_SEC};
        state_d = ST_START2;
      end
      ST_START2: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(prod_q);
        state_d          = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ns_d    = ns_carry ? NS_W'(ns_sum - {1'b0, NS_PER_SEC}) : ns_sum[NS_W-1:0];
        sec_d   = sec_q + whole_q[63:0] + {63'b0, ns_carry};
        last_d  = rd_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.seconds     = sec_q;
          out_d.nanoseconds = ns_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      freq_q      <= '0;
      last_q      <= '0;
      sec_q       <= '0;
      ns_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      freq_q      <= freq_d;
      last_q      <= last_d;
      sec_q       <= sec_d;
      ns_q        <= ns_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q    <= rd_d;
    whole_q <= whole_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
